FILE: src/akbf_pkg.sv
// Shared constants, types and helpers of the arm keypoint blend filter.
package akbf_pkg;

   localparam int FILTER_FRAC_BITS_DEF = 8;
   localparam int Q_DIR      = 14;       // fraction bits of unit vectors and positions
   localparam int DIR_W      = 16;
   localparam int LEN_W      = 10;
   localparam int WGT_W      = 16;       // Q0.16 weights and gains
   localparam int MM_W       = 16;
   localparam int POS_W      = 32;       // Q.14 millimetre positions
   localparam int FILT_W     = 24;       // low-pass state width
   localparam int LANES      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ONE_Q16    = 65536;
   localparam int HALF_Q16   = 32768;
   localparam int MM_MAX     = 32767;
   localparam int MM_MIN     = -32768;

   localparam logic [LEN_W-1:0]        UPPER_LEN_RST  = 10'd300;
   localparam logic [LEN_W-1:0]        FORE_LEN_RST   = 10'd250;
   localparam logic signed [MM_W-1:0]  Z_LOWEST_RST   = -16'sd400;
   localparam logic signed [MM_W-1:0]  Z_RAISED_RST   = -16'sd100;
   localparam logic [WGT_W-1:0]        TRUST_HIGH_RST = 16'd58982;
   localparam logic [WGT_W-1:0]        TRUST_LOW_RST  = 16'd13107;
   localparam logic [WGT_W-1:0]        SLOPE_RST      = 16'd153;
   localparam logic [WGT_W-1:0]        LP_GAIN_RST    = 16'd19661;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_UPPER_LEN  = 3'd0,
      CSR_FORE_LEN   = 3'd1,
      CSR_Z_LOWEST   = 3'd2,
      CSR_Z_RAISED   = 3'd3,
      CSR_TRUST_HIGH = 3'd4,
      CSR_TRUST_LOW  = 3'd5,
      CSR_SLOPE      = 3'd6,
      CSR_LP_GAIN    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      WSEL_HIGH = 2'd0,
      WSEL_LOW  = 2'd1,
      WSEL_MID  = 2'd2
   } wsel_type;

   typedef struct packed {
      logic scale;
      logic sum;
      logic bmul;
      logic bsum;
   } lane_ctl_type;

   typedef struct packed {
      logic wcmp;
      logic wmul;
      logic wfin;
      logic filt;
      logic lpmul;
      logic lpsum;
   } merge_ctl_type;

   // Round a Q.14 position to whole millimetres and saturate to 16 bits.
   function automatic logic signed [MM_W-1:0] q14_to_mm(input logic signed [POS_W-1:0] v);
      logic signed [POS_W:0] r;
      logic signed [MM_W-1:0] res;
      r = ((POS_W+1)'(v) + (POS_W+1)'(1 <<< (Q_DIR-1))) >>> Q_DIR;
      if (r > MM_MAX)
         res = MM_W'(MM_MAX);
      else if (r < MM_MIN)
         res = MM_W'(MM_MIN);
      else
         res = r[MM_W-1:0];
      return res;
   endfunction

endpackage

FILE: src/akbf_lane.sv
// One axis lane: segment scaling and camera blend of the elbow and wrist coordinate.
module akbf_lane import akbf_pkg::*; (
   input  logic                    clock,
   input  lane_ctl_type            ctl,
   input  logic [LEN_W-1:0]        upper_arm_mm,
   input  logic [LEN_W-1:0]        forearm_mm,
   input  logic signed [DIR_W-1:0] elbow_dir,
   input  logic signed [DIR_W-1:0] wrist_dir,
   input  logic                    cam_valid,
   input  logic signed [MM_W-1:0]  cam_elbow,
   input  logic signed [MM_W-1:0]  cam_wrist,
   input  logic [WGT_W-1:0]        alpha,
   output logic signed [POS_W-1:0] elbow_pos,
   output logic signed [POS_W-1:0] wrist_pos
);

   localparam int SEG_W = DIR_W + LEN_W + 1;
   localparam int CP_W  = MM_W + WGT_W + 1;
   localparam int OP_W  = POS_W + WGT_W + 2;
   localparam int BL_W  = OP_W + 2;

   logic signed [LEN_W:0]   upper_s, fore_s;
   logic signed [WGT_W:0]   cam_w_s;
   logic [WGT_W+1:0]        own_w;
   logic signed [WGT_W+1:0] own_w_s;

   logic signed [SEG_W-1:0] pe_ff, pe_in, pw_ff, pw_in;
   logic signed [CP_W-1:0]  ce_ff, ce_in, cw_ff, cw_in;
   logic signed [OP_W-1:0]  oe_ff, oe_in, ow_ff, ow_in;
   logic signed [POS_W-1:0] el_ff, el_in, wr_ff, wr_in;
   logic signed [BL_W-1:0]  el_sum, wr_sum, el_rnd, wr_rnd;

   assign upper_s = signed'({1'b0, upper_arm_mm});
   assign fore_s  = signed'({1'b0, forearm_mm});
   assign cam_w_s = signed'({1'b0, alpha});
   assign own_w   = (WGT_W+2)'(ONE_Q16) - (WGT_W+2)'(alpha);
   assign own_w_s = signed'(own_w);

   assign el_sum = (BL_W'(ce_ff) <<< Q_DIR) + BL_W'(oe_ff) + BL_W'(HALF_Q16);
   assign wr_sum = (BL_W'(cw_ff) <<< Q_DIR) + BL_W'(ow_ff) + BL_W'(HALF_Q16);
   assign el_rnd = el_sum >>> WGT_W;
   assign wr_rnd = wr_sum >>> WGT_W;

   always_comb begin
      pe_in = pe_ff;
      pw_in = pw_ff;
      ce_in = ce_ff;
      cw_in = cw_ff;
      oe_in = oe_ff;
      ow_in = ow_ff;
      el_in = el_ff;
      wr_in = wr_ff;
      if (ctl.scale) begin
         pe_in = elbow_dir * upper_s;
         pw_in = wrist_dir * fore_s;
      end
      if (ctl.sum) begin
         el_in = POS_W'(pe_ff);
         wr_in = POS_W'(pe_ff) + POS_W'(pw_ff);
      end
      if (ctl.bmul) begin
         ce_in = cam_elbow * cam_w_s;
         cw_in = cam_wrist * cam_w_s;
         oe_in = own_w_s * el_ff;
         ow_in = own_w_s * wr_ff;
      end
      // keep the own estimate when no camera points came with the request
      if (ctl.bsum && cam_valid) begin
         el_in = el_rnd[POS_W-1:0];
         wr_in = wr_rnd[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pe_ff <= pe_in;
      pw_ff <= pw_in;
      ce_ff <= ce_in;
      cw_ff <= cw_in;
      oe_ff <= oe_in;
      ow_ff <= ow_in;
      el_ff <= el_in;
      wr_ff <= wr_in;
   end

   assign elbow_pos = el_ff;
   assign wrist_pos = wr_ff;

endmodule

FILE: src/akbf_merge.sv
// Merge stage: camera weight from wrist Z, X-axis low-pass and X output rounding.
module akbf_merge import akbf_pkg::*; #(
   parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  merge_ctl_type           ctl,
   input  logic signed [POS_W-1:0] wrist_z,
   input  logic signed [POS_W-1:0] elbow_x,
   input  logic signed [POS_W-1:0] wrist_x,
   input  logic signed [MM_W-1:0]  z_lowest,
   input  logic signed [MM_W-1:0]  z_raised,
   input  logic [WGT_W-1:0]        trust_high,
   input  logic [WGT_W-1:0]        trust_low,
   input  logic [WGT_W-1:0]        blend_slope,
   input  logic [WGT_W-1:0]        lowpass_gain,
   output logic [WGT_W-1:0]        alpha,
   output logic signed [MM_W-1:0]  elbow_x_mm,
   output logic signed [MM_W-1:0]  wrist_x_mm
);

   localparam int ZC_W  = POS_W + 1;
   localparam int WP_W  = ZC_W + WGT_W + 1;
   localparam int A_W   = WP_W + 1;
   localparam int TF_W  = POS_W + 4;
   localparam int SH    = (FILTER_FRAC_BITS <= Q_DIR) ? Q_DIR - FILTER_FRAC_BITS : 0;
   localparam int LSH   = (FILTER_FRAC_BITS > Q_DIR) ? FILTER_FRAC_BITS - Q_DIR : 0;
   localparam int RND   = (SH > 0) ? (1 << (SH - 1)) : 0;
   localparam int ORND  = (FILTER_FRAC_BITS > 0) ? (1 << (FILTER_FRAC_BITS - 1)) : 0;
   localparam int S_MAX = (1 << (FILT_W - 1)) - 1;
   localparam int S_MIN = -(1 << (FILT_W - 1));
   localparam int NP_W  = FILT_W + WGT_W + 1;
   localparam int SP_W  = FILT_W + WGT_W + 2;
   localparam int LS_W  = SP_W + 1;
   localparam int OW    = FILT_W + 1;

   function automatic logic signed [FILT_W-1:0] to_filter(input logic signed [POS_W-1:0] v);
      logic signed [TF_W-1:0] t;
      logic signed [FILT_W-1:0] res;
      t = ((TF_W'(v) + TF_W'(RND)) >>> SH) <<< LSH;
      if (t > S_MAX)
         res = FILT_W'(S_MAX);
      else if (t < S_MIN)
         res = FILT_W'(S_MIN);
      else
         res = t[FILT_W-1:0];
      return res;
   endfunction

   function automatic logic signed [FILT_W-1:0] lp_sum(input logic signed [NP_W-1:0] pn,
                                                       input logic signed [SP_W-1:0] ps);
      logic signed [LS_W-1:0] t;
      logic signed [FILT_W-1:0] res;
      t = (LS_W'(pn) + LS_W'(ps) + LS_W'(HALF_Q16)) >>> WGT_W;
      if (t > S_MAX)
         res = FILT_W'(S_MAX);
      else if (t < S_MIN)
         res = FILT_W'(S_MIN);
      else
         res = t[FILT_W-1:0];
      return res;
   endfunction

   function automatic logic signed [MM_W-1:0] filt_to_mm(input logic signed [FILT_W-1:0] v);
      logic signed [OW-1:0] t;
      logic signed [MM_W-1:0] res;
      t = (OW'(v) + OW'(ORND)) >>> FILTER_FRAC_BITS;
      if (t > MM_MAX)
         res = MM_W'(MM_MAX);
      else if (t < MM_MIN)
         res = MM_W'(MM_MIN);
      else
         res = t[MM_W-1:0];
      return res;
   endfunction

   logic signed [ZC_W-1:0]   wz_w, lo_w, hi_w;
   wsel_type                 sel_ff, sel_in;
   logic signed [ZC_W-1:0]   diff_ff, diff_in;
   logic signed [WP_W-1:0]   wprod_ff, wprod_in, wprod_rnd;
   logic signed [A_W-1:0]    a_raw, amin_s, amax_s;
   logic [WGT_W-1:0]         amin, amax;
   logic [WGT_W-1:0]         alpha_ff, alpha_in;
   logic signed [FILT_W-1:0] ex_ff, ex_in, wx_ff, wx_in;
   logic signed [WGT_W:0]    gain_s;
   logic [WGT_W+1:0]         keep_w;
   logic signed [WGT_W+1:0]  keep_s;
   logic signed [NP_W-1:0]   en_ff, en_in, wn_ff, wn_in;
   logic signed [SP_W-1:0]   es_ff, es_in, ws_ff, ws_in;
   logic signed [FILT_W-1:0] es_state_ff, es_state_in, ws_state_ff, ws_state_in;
   logic                     seeded_ff, seeded_in;

   assign wz_w = ZC_W'(wrist_z);
   assign lo_w = ZC_W'(z_lowest) <<< Q_DIR;
   assign hi_w = ZC_W'(z_raised) <<< Q_DIR;

   assign wprod_rnd = (wprod_ff + WP_W'(1 <<< (Q_DIR - 1))) >>> Q_DIR;
   assign a_raw     = A_W'(signed'({1'b0, trust_high})) - A_W'(wprod_rnd);
   assign amin      = (trust_high < trust_low) ? trust_high : trust_low;
   assign amax      = (trust_high < trust_low) ? trust_low : trust_high;
   assign amin_s    = A_W'(signed'({1'b0, amin}));
   assign amax_s    = A_W'(signed'({1'b0, amax}));

   assign gain_s = signed'({1'b0, lowpass_gain});
   assign keep_w = (WGT_W+2)'(ONE_Q16) - (WGT_W+2)'(lowpass_gain);
   assign keep_s = signed'(keep_w);

   always_comb begin
      sel_in      = sel_ff;
      diff_in     = diff_ff;
      wprod_in    = wprod_ff;
      alpha_in    = alpha_ff;
      ex_in       = ex_ff;
      wx_in       = wx_ff;
      en_in       = en_ff;
      wn_in       = wn_ff;
      es_in       = es_ff;
      ws_in       = ws_ff;
      es_state_in = es_state_ff;
      ws_state_in = ws_state_ff;
      seeded_in   = seeded_ff;
      if (ctl.wcmp) begin
         // the low threshold is tested first and wins when thresholds cross
         if (wz_w <= lo_w)
            sel_in = WSEL_HIGH;
         else if (wz_w >= hi_w)
            sel_in = WSEL_LOW;
         else
            sel_in = WSEL_MID;
         diff_in = wz_w - lo_w;
      end
      if (ctl.wmul)
         wprod_in = diff_ff * signed'({1'b0, blend_slope});
      if (ctl.wfin) begin
         case (sel_ff)
            WSEL_HIGH: alpha_in = trust_high;
            WSEL_LOW:  alpha_in = trust_low;
            WSEL_MID: begin
               if (a_raw < amin_s)
                  alpha_in = amin;
               else if (a_raw > amax_s)
                  alpha_in = amax;
               else
                  alpha_in = a_raw[WGT_W-1:0];
            end
            default:   alpha_in = trust_high;
         endcase
      end
      if (ctl.filt) begin
         ex_in = to_filter(elbow_x);
         wx_in = to_filter(wrist_x);
      end
      if (ctl.lpmul) begin
         en_in = ex_ff * gain_s;
         wn_in = wx_ff * gain_s;
         es_in = es_state_ff * keep_s;
         ws_in = ws_state_ff * keep_s;
      end
      if (ctl.lpsum) begin
         // seed on the first request, filter afterwards
         if (!seeded_ff) begin
            es_state_in = ex_ff;
            ws_state_in = wx_ff;
         end else begin
            es_state_in = lp_sum(en_ff, es_ff);
            ws_state_in = lp_sum(wn_ff, ws_ff);
         end
         seeded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff   <= sel_in;
      diff_ff  <= diff_in;
      wprod_ff <= wprod_in;
      alpha_ff <= alpha_in;
      ex_ff    <= ex_in;
      wx_ff    <= wx_in;
      en_ff    <= en_in;
      wn_ff    <= wn_in;
      es_ff    <= es_in;
      ws_ff    <= ws_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         es_state_ff <= '0;
         ws_state_ff <= '0;
         seeded_ff   <= 1'b0;
      end else begin
         es_state_ff <= es_state_in;
         ws_state_ff <= ws_state_in;
         seeded_ff   <= seeded_in;
      end
   end

   assign alpha      = alpha_ff;
   assign elbow_x_mm = filt_to_mm(es_state_ff);
   assign wrist_x_mm = filt_to_mm(ws_state_ff);

endmodule

FILE: src/arm_keypoint_blend_filter.sv
// Top level of the arm keypoint blend filter: request capture, sequencing, lanes and result register.
//
// Requests carry the upper-arm and forearm unit vectors (Q1.14) and optional camera elbow
// and wrist points; a request is taken at a clock edge with req_valid high and req_stall
// low. Each result gives the fused elbow and wrist coordinates in millimetres, X filtered.
// Three axis lanes scale and blend in parallel; a merge stage forms the camera weight from
// the wrist Z and runs the two X low-pass filters. The sequencer steps one request through
// scale, sum, weight compare, weight multiply, weight clamp, blend multiply, blend sum,
// filter conversion, filter multiply and filter update, one step per cycle.
// req_stall is high while a request is in work, so the next one is taken only once it is done.
// The result register holds a finished result while rsp_stall is high; the next request is
// taken meanwhile and waits in its last step until the register frees up.
// Reset (synchronous, active high) restores the register defaults, unseeds the X filters
// and empties the block. Registers are written through csr_we/csr_addr/csr_wdata; the user
// must write them only while idle, as the block itself does not enforce it.
module arm_keypoint_blend_filter import akbf_pkg::*; #(
   parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [DIR_W-1:0] req_elbow_dir_x,
   input  logic signed [DIR_W-1:0] req_elbow_dir_y,
   input  logic signed [DIR_W-1:0] req_elbow_dir_z,
   input  logic signed [DIR_W-1:0] req_wrist_dir_x,
   input  logic signed [DIR_W-1:0] req_wrist_dir_y,
   input  logic signed [DIR_W-1:0] req_wrist_dir_z,
   input  logic                    req_cam_valid,
   input  logic [3*MM_W-1:0]       req_cam_elbow_xyz,
   input  logic [3*MM_W-1:0]       req_cam_wrist_xyz,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [MM_W-1:0]  rsp_elbow_x,
   output logic signed [MM_W-1:0]  rsp_elbow_y,
   output logic signed [MM_W-1:0]  rsp_elbow_z,
   output logic signed [MM_W-1:0]  rsp_wrist_x,
   output logic signed [MM_W-1:0]  rsp_wrist_y,
   output logic signed [MM_W-1:0]  rsp_wrist_z,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_SCALE = 12'b0000_0000_0010,
      ST_SUM   = 12'b0000_0000_0100,
      ST_WCMP  = 12'b0000_0000_1000,
      ST_WMUL  = 12'b0000_0001_0000,
      ST_WFIN  = 12'b0000_0010_0000,
      ST_BMUL  = 12'b0000_0100_0000,
      ST_BSUM  = 12'b0000_1000_0000,
      ST_FILT  = 12'b0001_0000_0000,
      ST_LPMUL = 12'b0010_0000_0000,
      ST_LPSUM = 12'b0100_0000_0000,
      ST_OUT   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]        upper_arm_mm_ff, forearm_mm_ff;
   logic signed [MM_W-1:0]  z_lowest_ff, z_raised_ff;
   logic [WGT_W-1:0]        trust_high_ff, trust_low_ff, slope_ff, lp_gain_ff;

   logic signed [DIR_W-1:0] e_dir_ff [LANES];
   logic signed [DIR_W-1:0] w_dir_ff [LANES];
   logic signed [MM_W-1:0]  cam_e_ff [LANES];
   logic signed [MM_W-1:0]  cam_w_ff [LANES];
   logic                    cam_valid_ff;

   logic signed [POS_W-1:0] elbow_pos [LANES];
   logic signed [POS_W-1:0] wrist_pos [LANES];
   logic [WGT_W-1:0]        alpha;
   logic signed [MM_W-1:0]  elbow_x_mm, wrist_x_mm;

   lane_ctl_type            lane_ctl;
   merge_ctl_type           merge_ctl;

   logic                    accept, load_rsp;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [MM_W-1:0]  ex_ff, ey_ff, ez_ff, wx_ff, wy_ff, wz_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_rsp  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_arm_mm_ff <= UPPER_LEN_RST;
         forearm_mm_ff   <= FORE_LEN_RST;
         z_lowest_ff     <= Z_LOWEST_RST;
         z_raised_ff     <= Z_RAISED_RST;
         trust_high_ff   <= TRUST_HIGH_RST;
         trust_low_ff    <= TRUST_LOW_RST;
         slope_ff        <= SLOPE_RST;
         lp_gain_ff      <= LP_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_UPPER_LEN:  upper_arm_mm_ff <= csr_wdata[LEN_W-1:0];
            CSR_FORE_LEN:   forearm_mm_ff   <= csr_wdata[LEN_W-1:0];
            CSR_Z_LOWEST:   z_lowest_ff     <= signed'(csr_wdata[MM_W-1:0]);
            CSR_Z_RAISED:   z_raised_ff     <= signed'(csr_wdata[MM_W-1:0]);
            CSR_TRUST_HIGH: trust_high_ff   <= csr_wdata[WGT_W-1:0];
            CSR_TRUST_LOW:  trust_low_ff    <= csr_wdata[WGT_W-1:0];
            CSR_SLOPE:      slope_ff        <= csr_wdata[WGT_W-1:0];
            CSR_LP_GAIN:    lp_gain_ff      <= csr_wdata[WGT_W-1:0];
            default: ;
         endcase
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (accept) begin
         e_dir_ff[0]  <= req_elbow_dir_x;
         e_dir_ff[1]  <= req_elbow_dir_y;
         e_dir_ff[2]  <= req_elbow_dir_z;
         w_dir_ff[0]  <= req_wrist_dir_x;
         w_dir_ff[1]  <= req_wrist_dir_y;
         w_dir_ff[2]  <= req_wrist_dir_z;
         cam_valid_ff <= req_cam_valid;
         for (int i = 0; i < LANES; i++) begin
            cam_e_ff[i] <= signed'(req_cam_elbow_xyz[i*MM_W +: MM_W]);
            cam_w_ff[i] <= signed'(req_cam_wrist_xyz[i*MM_W +: MM_W]);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_SUM;
         ST_SUM:   state_in = ST_WCMP;
         ST_WCMP:  state_in = ST_WMUL;
         ST_WMUL:  state_in = ST_WFIN;
         ST_WFIN:  state_in = ST_BMUL;
         ST_BMUL:  state_in = ST_BSUM;
         ST_BSUM:  state_in = ST_FILT;
         ST_FILT:  state_in = ST_LPMUL;
         ST_LPMUL: state_in = ST_LPSUM;
         ST_LPSUM: state_in = ST_OUT;
         ST_OUT:   if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign lane_ctl.scale  = (state_ff == ST_SCALE);
   assign lane_ctl.sum    = (state_ff == ST_SUM);
   assign lane_ctl.bmul   = (state_ff == ST_BMUL);
   assign lane_ctl.bsum   = (state_ff == ST_BSUM);
   assign merge_ctl.wcmp  = (state_ff == ST_WCMP);
   assign merge_ctl.wmul  = (state_ff == ST_WMUL);
   assign merge_ctl.wfin  = (state_ff == ST_WFIN);
   assign merge_ctl.filt  = (state_ff == ST_FILT);
   assign merge_ctl.lpmul = (state_ff == ST_LPMUL);
   assign merge_ctl.lpsum = (state_ff == ST_LPSUM);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      akbf_lane u_lane (
         .clock        (clock),
         .ctl          (lane_ctl),
         .upper_arm_mm (upper_arm_mm_ff),
         .forearm_mm   (forearm_mm_ff),
         .elbow_dir    (e_dir_ff[i]),
         .wrist_dir    (w_dir_ff[i]),
         .cam_valid    (cam_valid_ff),
         .cam_elbow    (cam_e_ff[i]),
         .cam_wrist    (cam_w_ff[i]),
         .alpha        (alpha),
         .elbow_pos    (elbow_pos[i]),
         .wrist_pos    (wrist_pos[i])
      );
   end

   akbf_merge #(
      .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .ctl          (merge_ctl),
      .wrist_z      (wrist_pos[2]),
      .elbow_x      (elbow_pos[0]),
      .wrist_x      (wrist_pos[0]),
      .z_lowest     (z_lowest_ff),
      .z_raised     (z_raised_ff),
      .trust_high   (trust_high_ff),
      .trust_low    (trust_low_ff),
      .blend_slope  (slope_ff),
      .lowpass_gain (lp_gain_ff),
      .alpha        (alpha),
      .elbow_x_mm   (elbow_x_mm),
      .wrist_x_mm   (wrist_x_mm)
   );

   // result register: hold while stalled, refill when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
      if (load_rsp)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         ex_ff <= elbow_x_mm;
         ey_ff <= q14_to_mm(elbow_pos[1]);
         ez_ff <= q14_to_mm(elbow_pos[2]);
         wx_ff <= wrist_x_mm;
         wy_ff <= q14_to_mm(wrist_pos[1]);
         wz_ff <= q14_to_mm(wrist_pos[2]);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_elbow_x = ex_ff;
   assign rsp_elbow_y = ey_ff;
   assign rsp_elbow_z = ez_ff;
   assign rsp_wrist_x = wx_ff;
   assign rsp_wrist_y = wy_ff;
   assign rsp_wrist_z = wz_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCALE)
      else $error("accepted request did not start the step sequence");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_out_done: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("output step did not deliver the result");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the arm keypoint blend filter: directed and random frames.
module tb;
   import akbf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FFB            = FILTER_FRAC_BITS_DEF;
   localparam longint Q14_ONE        = longint'(1) <<< Q_DIR;
   localparam longint S24_MAX        = (longint'(1) <<< (FILT_W - 1)) - 1;
   localparam longint S24_MIN        = -(longint'(1) <<< (FILT_W - 1));
   localparam int     DRAIN_CYCLES   = 24;
   localparam int     WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic signed [DIR_W-1:0] elbow_dx;
      logic signed [DIR_W-1:0] elbow_dy;
      logic signed [DIR_W-1:0] elbow_dz;
      logic signed [DIR_W-1:0] wrist_dx;
      logic signed [DIR_W-1:0] wrist_dy;
      logic signed [DIR_W-1:0] wrist_dz;
      logic                    cam_valid;
      logic [3*MM_W-1:0]       cam_elbow;
      logic [3*MM_W-1:0]       cam_wrist;
   } frame_type;

   typedef struct packed {
      logic signed [MM_W-1:0] elbow_x;
      logic signed [MM_W-1:0] elbow_y;
      logic signed [MM_W-1:0] elbow_z;
      logic signed [MM_W-1:0] wrist_x;
      logic signed [MM_W-1:0] wrist_y;
      logic signed [MM_W-1:0] wrist_z;
   } pose_type;

   typedef logic [CSR_DATA_W-1:0] reg_set_type [8];

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [DIR_W-1:0] req_elbow_dir_x = '0;
   logic signed [DIR_W-1:0] req_elbow_dir_y = '0;
   logic signed [DIR_W-1:0] req_elbow_dir_z = '0;
   logic signed [DIR_W-1:0] req_wrist_dir_x = '0;
   logic signed [DIR_W-1:0] req_wrist_dir_y = '0;
   logic signed [DIR_W-1:0] req_wrist_dir_z = '0;
   logic                    req_cam_valid = 1'b0;
   logic [3*MM_W-1:0]       req_cam_elbow_xyz = '0;
   logic [3*MM_W-1:0]       req_cam_wrist_xyz = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b1;
   logic signed [MM_W-1:0]  rsp_elbow_x;
   logic signed [MM_W-1:0]  rsp_elbow_y;
   logic signed [MM_W-1:0]  rsp_elbow_z;
   logic signed [MM_W-1:0]  rsp_wrist_x;
   logic signed [MM_W-1:0]  rsp_wrist_y;
   logic signed [MM_W-1:0]  rsp_wrist_z;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   arm_keypoint_blend_filter uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_elbow_dir_x   (req_elbow_dir_x),
      .req_elbow_dir_y   (req_elbow_dir_y),
      .req_elbow_dir_z   (req_elbow_dir_z),
      .req_wrist_dir_x   (req_wrist_dir_x),
      .req_wrist_dir_y   (req_wrist_dir_y),
      .req_wrist_dir_z   (req_wrist_dir_z),
      .req_cam_valid     (req_cam_valid),
      .req_cam_elbow_xyz (req_cam_elbow_xyz),
      .req_cam_wrist_xyz (req_cam_wrist_xyz),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_elbow_x       (rsp_elbow_x),
      .rsp_elbow_y       (rsp_elbow_y),
      .rsp_elbow_z       (rsp_elbow_z),
      .rsp_wrist_x       (rsp_wrist_x),
      .rsp_wrist_y       (rsp_wrist_y),
      .rsp_wrist_z       (rsp_wrist_z),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Register copy and filter state of the fusion predictor
   logic [LEN_W-1:0]       upper_arm_mm = UPPER_LEN_RST;
   logic [LEN_W-1:0]       forearm_mm   = FORE_LEN_RST;
   logic signed [MM_W-1:0] z_lowest     = Z_LOWEST_RST;
   logic signed [MM_W-1:0] z_raised     = Z_RAISED_RST;
   logic [WGT_W-1:0]       trust_high   = TRUST_HIGH_RST;
   logic [WGT_W-1:0]       trust_low    = TRUST_LOW_RST;
   logic [WGT_W-1:0]       blend_slope  = SLOPE_RST;
   logic [WGT_W-1:0]       lp_gain      = LP_GAIN_RST;
   longint                 elbow_x_lp   = 0;
   longint                 wrist_x_lp   = 0;
   bit                     lp_seeded    = 1'b0;

   pose_type expected_poses[$];
   int    mismatches   = 0;
   int    quiet_cycles = 0;
   bit    req_calm     = 1'b0;
   bit    rsp_calm     = 1'b0;

   function automatic longint rnd_shift(longint v, int n);
      if (n <= 0)
         return v;
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic signed [MM_W-1:0] to_mm(longint v, int frac);
      longint r;
      r = clip(rnd_shift(v, frac), MM_MIN, MM_MAX);
      return MM_W'(r);
   endfunction

   function automatic longint to_filter_fmt(longint q14);
      longint v;
      if (FFB - Q_DIR <= 0)
         v = rnd_shift(q14, Q_DIR - FFB);
      else
         v = q14 * (longint'(1) <<< (FFB - Q_DIR));
      return clip(v, S24_MIN, S24_MAX);
   endfunction

   function automatic longint smooth_x(longint s, longint x);
      longint g;
      g = longint'(lp_gain);
      return clip(rnd_shift(g * x + (ONE_Q16 - g) * s, 16), S24_MIN, S24_MAX);
   endfunction

   // Camera weight from wrist Z; the lower threshold is tested first
   function automatic longint camera_weight(longint wz);
      longint lo, hi, th, tl, a;
      lo = longint'(z_lowest) * Q14_ONE;
      hi = longint'(z_raised) * Q14_ONE;
      th = longint'(trust_high);
      tl = longint'(trust_low);
      if (wz <= lo)
         return th;
      if (wz >= hi)
         return tl;
      a = th - rnd_shift(longint'(blend_slope) * (wz - lo), Q_DIR);
      return th < tl ? clip(a, th, tl) : clip(a, tl, th);
   endfunction

   function automatic pose_type fuse_frame(frame_type f);
      longint elb[3];
      longint wri[3];
      longint ed[3];
      longint wd[3];
      longint alpha, ce, cw;
      pose_type p;
      ed = '{longint'(f.elbow_dx), longint'(f.elbow_dy), longint'(f.elbow_dz)};
      wd = '{longint'(f.wrist_dx), longint'(f.wrist_dy), longint'(f.wrist_dz)};
      for (int i = 0; i < 3; i++) begin
         elb[i] = ed[i] * longint'(upper_arm_mm);
         wri[i] = elb[i] + wd[i] * longint'(forearm_mm);
      end
      alpha = camera_weight(wri[2]);
      if (f.cam_valid) begin
         for (int i = 0; i < 3; i++) begin
            ce = longint'($signed(f.cam_elbow[16*i +: 16])) * Q14_ONE;
            cw = longint'($signed(f.cam_wrist[16*i +: 16])) * Q14_ONE;
            elb[i] = rnd_shift(alpha * ce + (ONE_Q16 - alpha) * elb[i], 16);
            wri[i] = rnd_shift(alpha * cw + (ONE_Q16 - alpha) * wri[i], 16);
         end
      end
      if (!lp_seeded) begin
         elbow_x_lp = to_filter_fmt(elb[0]);
         wrist_x_lp = to_filter_fmt(wri[0]);
         lp_seeded  = 1'b1;
      end else begin
         elbow_x_lp = smooth_x(elbow_x_lp, to_filter_fmt(elb[0]));
         wrist_x_lp = smooth_x(wrist_x_lp, to_filter_fmt(wri[0]));
      end
      p.elbow_x = to_mm(elbow_x_lp, FFB);
      p.elbow_y = to_mm(elb[1], Q_DIR);
      p.elbow_z = to_mm(elb[2], Q_DIR);
      p.wrist_x = to_mm(wrist_x_lp, FFB);
      p.wrist_y = to_mm(wri[1], Q_DIR);
      p.wrist_z = to_mm(wri[2], Q_DIR);
      return p;
   endfunction

   function automatic int draw_wait(ref bit calm);
      if ($urandom_range(0, 39) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic frame_type make_frame(int ex, int ey, int ez, int wx, int wy, int wz,
                                            bit cam, logic [47:0] ce, logic [47:0] cw);
      frame_type f;
      f.elbow_dx  = DIR_W'(ex);
      f.elbow_dy  = DIR_W'(ey);
      f.elbow_dz  = DIR_W'(ez);
      f.wrist_dx  = DIR_W'(wx);
      f.wrist_dy  = DIR_W'(wy);
      f.wrist_dz  = DIR_W'(wz);
      f.cam_valid = cam;
      f.cam_elbow = ce;
      f.cam_wrist = cw;
      return f;
   endfunction

   function automatic int rand_dir();
      int pick;
      pick = $urandom_range(0, 31);
      if (pick == 0)
         return $urandom_range(0, 65535) - 32768;
      if (pick == 1)
         return $urandom_range(0, 1) ? 16384 : -16384;
      return $urandom_range(0, 32768) - 16384;
   endfunction

   function automatic logic [47:0] rand_point();
      logic [47:0] v;
      if ($urandom_range(0, 1)) begin
         v = {$urandom, $urandom};
      end else begin
         for (int i = 0; i < 3; i++)
            v[16*i +: 16] = 16'($urandom_range(0, 2400) - 1200);
      end
      return v;
   endfunction

   function automatic frame_type rand_frame();
      return make_frame(rand_dir(), rand_dir(), rand_dir(), rand_dir(), rand_dir(), rand_dir(),
                        $urandom_range(0, 3) != 0, rand_point(), rand_point());
   endfunction

   // Hold the request until accepted, then book its expected pose
   task automatic send_frame(frame_type f);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_elbow_dir_x   <= f.elbow_dx;
      req_elbow_dir_y   <= f.elbow_dy;
      req_elbow_dir_z   <= f.elbow_dz;
      req_wrist_dir_x   <= f.wrist_dx;
      req_wrist_dir_y   <= f.wrist_dy;
      req_wrist_dir_z   <= f.wrist_dz;
      req_cam_valid     <= f.cam_valid;
      req_cam_elbow_xyz <= f.cam_elbow;
      req_cam_wrist_xyz <= f.cam_wrist;
      do @(posedge clock); while (req_stall);
      expected_poses.push_back(fuse_frame(f));
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_poses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all eight registers with the block idle
   task automatic load_regs(reg_set_type c);
      drain_block();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= csr_index_type'(i);
         csr_wdata <= c[i];
         @(posedge clock);
         case (csr_index_type'(i))
            CSR_UPPER_LEN:  upper_arm_mm = c[i][LEN_W-1:0];
            CSR_FORE_LEN:   forearm_mm   = c[i][LEN_W-1:0];
            CSR_Z_LOWEST:   z_lowest     = c[i];
            CSR_Z_RAISED:   z_raised     = c[i];
            CSR_TRUST_HIGH: trust_high   = c[i];
            CSR_TRUST_LOW:  trust_low    = c[i];
            CSR_SLOPE:      blend_slope  = c[i];
            CSR_LP_GAIN:    lp_gain      = c[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   function automatic reg_set_type make_regs(int ul, int fl, int zl, int zr,
                                             int th, int tl, int sl, int g);
      reg_set_type c;
      c[CSR_UPPER_LEN]  = CSR_DATA_W'(ul);
      c[CSR_FORE_LEN]   = CSR_DATA_W'(fl);
      c[CSR_Z_LOWEST]   = CSR_DATA_W'(zl);
      c[CSR_Z_RAISED]   = CSR_DATA_W'(zr);
      c[CSR_TRUST_HIGH] = CSR_DATA_W'(th);
      c[CSR_TRUST_LOW]  = CSR_DATA_W'(tl);
      c[CSR_SLOPE]      = CSR_DATA_W'(sl);
      c[CSR_LP_GAIN]    = CSR_DATA_W'(g);
      return c;
   endfunction

   function automatic reg_set_type rand_regs();
      int lo, hi, t;
      lo = $urandom_range(0, 1600) - 1000;
      hi = lo + $urandom_range(1, 700);
      if ($urandom_range(0, 5) == 0) begin
         t  = lo;
         lo = hi;
         hi = t;
      end else if ($urandom_range(0, 7) == 0) begin
         lo = $urandom_range(0, 65535) - 32768;
         hi = $urandom_range(0, 65535) - 32768;
      end
      // upper bits of the length writes are random and must be dropped
      return make_regs($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(50, 600),
                       $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(50, 600),
                       lo, hi, $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 800),
                       $urandom_range(0, 65535));
   endfunction

   // Default registers: seeding frame, vector extremes, camera extremes
   task automatic test_seed_and_extremes();
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1'b0, '0, '0));
      send_frame(make_frame(16384, 16384, 16384, 16384, 16384, 16384, 1'b0, '0, '0));
      send_frame(make_frame(-16384, -16384, -16384, -16384, -16384, -16384, 1'b0, '0, '0));
      send_frame(make_frame(32767, 32767, 32767, 32767, 32767, 32767, 1'b1,
                            48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF));
      send_frame(make_frame(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1,
                            48'h8000_8000_8000, 48'h8000_8000_8000));
      send_frame(make_frame(16384, -16384, -16384, -16384, 16384, -16384, 1'b1,
                            48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000));
      send_frame(make_frame(-16384, 16384, 16384, 16384, -16384, 16384, 1'b1,
                            48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1'b1, 48'h0000_0190_FE70, 48'h0000_0000_0000));
   endtask

   // Each weight region and its edges, then inverted thresholds and a rising ramp
   task automatic test_weight_regions();
      logic [47:0] ce, cw;
      ce = 48'hFE70_00C8_0064;
      cw = 48'hFF38_012C_FF9C;
      load_regs(make_regs(100, 100, -100, 100, 60000, 5000, 300, 30000));
      send_frame(make_frame(0, 0, -16384, 0, 0, 0, 1'b1, ce, cw));
      send_frame(make_frame(0, 0, -16384, 0, 0, -1, 1'b1, ce, cw));
      send_frame(make_frame(0, 0, -16384, 0, 0, 1, 1'b1, ce, cw));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1'b1, ce, cw));
      send_frame(make_frame(0, 0, 16384, 0, 0, -1, 1'b1, ce, cw));
      send_frame(make_frame(0, 0, 16384, 0, 0, 0, 1'b1, ce, cw));
      load_regs(make_regs(100, 100, 100, -100, 65535, 1000, 300, 65535));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1'b1, ce, cw));
      send_frame(make_frame(0, 0, 16384, 0, 0, 16384, 1'b1, ce, cw));
      load_regs(make_regs(100, 100, -100, 100, 1000, 60000, 65535, 0));
      send_frame(make_frame(0, 0, -8192, 0, 0, 0, 1'b1, ce, cw));
      send_frame(make_frame(0, 0, 8192, 0, 0, 0, 1'b1, ce, cw));
   endtask

   task automatic test_register_extremes();
      reg_set_type corners[4];
      corners[0] = make_regs(0, 0, -32768, -32768, 0, 0, 0, 0);
      corners[1] = make_regs(1023, 1023, 32767, 32767, 65535, 65535, 65535, 65535);
      corners[2] = make_regs(1023, 1023, -32768, 32767, 65535, 0, 65535, 65535);
      corners[3] = make_regs(1023, 1023, -32768, 32767, 0, 65535, 1, 1);
      foreach (corners[k]) begin
         load_regs(corners[k]);
         repeat (40) send_frame(rand_frame());
      end
   endtask

   task automatic test_random_frames();
      for (int phase = 0; phase < 12; phase++) begin
         load_regs(rand_regs());
         repeat (150) send_frame(rand_frame());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_seed_and_extremes();
      test_weight_regions();
      test_register_extremes();
      test_random_frames();
      drain_block();
      if (mismatches == 0)
         $display("[arm_keypoint_blend_filter] OK");
      else
         $display("[arm_keypoint_blend_filter] ERROR");
      $finish;
   end

   // Result side: stall for a drawn number of cycles, then take one result
   initial begin
      int n;
      forever begin
         n = draw_wait(rsp_calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      pose_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_elbow_x, rsp_elbow_y, rsp_elbow_z, rsp_wrist_x, rsp_wrist_y, rsp_wrist_z};
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: elbow %0d %0d %0d wrist %0d %0d %0d",
                        got.elbow_x, got.elbow_y, got.elbow_z,
                        got.wrist_x, got.wrist_y, got.wrist_z);
         end else begin
            want = expected_poses.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: elbow %0d %0d %0d wrist %0d %0d %0d,",
                            " expected elbow %0d %0d %0d wrist %0d %0d %0d"},
                           got.elbow_x, got.elbow_y, got.elbow_z,
                           got.wrist_x, got.wrist_y, got.wrist_z,
                           want.elbow_x, want.elbow_y, want.elbow_z,
                           want.wrist_x, want.wrist_y, want.wrist_z);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("[arm_keypoint_blend_filter] ERROR");
      $finish;
   end

endmodule
